// ===== design/slab_bitmap_allocator_assert.svh =====
// Assertion helpers used by the allocator RTL.
`ifndef SLAB_BITMAP_ALLOCATOR_ASSERT_SVH
`define SLAB_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SBA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slab allocator check failed");

// Next-cycle implication.
`define SBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slab allocator check failed");

`endif

// ===== design/sba_pkg.sv =====
package sba_pkg;

  localparam int unsigned ADDR_W        = 48;
  localparam int unsigned SIZE_W        = 17;
  localparam int unsigned SLOT_W        = 10;
  localparam int unsigned FREE_W        = 11;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 48;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_W         = 5;
  localparam int unsigned RST_OBJ_BYTES = 64;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_REINIT = 2'd2,
    ACT_NOP    = 2'd3
  } sba_action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } sba_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBJECT_BYTES = 1'd0,
    CFG_SLAB_BASE    = 1'd1
  } sba_cfg_e;

  typedef struct packed {
    sba_action_e       action;
    logic [ADDR_W-1:0] free_address;
  } sba_req_t;

  typedef struct packed {
    sba_status_e       status;
    logic [ADDR_W-1:0] granted_address;
    logic [SLOT_W-1:0] slot_index;
    logic [FREE_W-1:0] free_left;
  } sba_rsp_t;

endpackage

// ===== design/sba_stream_if.sv =====
interface sba_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/slab_bitmap_allocator.sv =====
// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    action, free_address
// rsp_o     out  valid/ready    status, granted_address, slot_index, free_left
// cfg       in   cfg_we_i       cfg_idx_i selects object_bytes or slab_base
//
// One item at a time. Free, and reinitialize when the bitmap depth does not fit
// inside the slab, use the bit-serial divider, one quotient bit per cycle.
// Reset clears the bitmap row-valid bits at once: no clearing pass.
// A finished result waits in the output register; the next request is taken
// meanwhile and only its own completion stalls on rsp_o.ready.
`include "slab_bitmap_allocator_assert.svh"

module slab_bitmap_allocator
  import sba_pkg::*;
#(
  parameter int unsigned SLAB_BYTES  = 65536,
  parameter int unsigned MAX_OBJECTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sba_stream_if.sink            req_i,
  sba_stream_if.source          rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned OFF_W  = CNT_W + SIZE_W;
  localparam int unsigned ROWS   = (MAX_OBJECTS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned GW     = ROW_W + BIT_W;
  localparam int unsigned XW     = GW + CNT_W;
  localparam int unsigned DCNT_W = $clog2(CNT_W);
  localparam int unsigned RST_Q  = SLAB_BYTES / RST_OBJ_BYTES;
  localparam int unsigned RST_COUNT = (RST_Q > MAX_OBJECTS) ? MAX_OBJECTS : RST_Q;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_WORD,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_POST,
    S_F_WR,
    S_DONE
  } state_e;

  state_e            state_q;
  sba_action_e       act_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] obj_bytes_q;
  logic [ADDR_W-1:0] slab_base_q;
  logic [CNT_W-1:0]  object_count_q;
  logic [CNT_W-1:0]  free_count_q;
  logic [ROWS-1:0]   row_vld_q;
  logic [ROWS-1:0]   row_full_q;
  logic [ROW_W-1:0]  row_q;
  logic [BIT_W-1:0]  bit_q;
  logic [CNT_W-1:0]  slot_q;
  logic [OFF_W-1:0]  mul_q;
  logic [OFF_W-1:0]  rem_q;
  logic [OFF_W-1:0]  dv_q;
  logic [CNT_W-1:0]  quo_q;
  logic [DCNT_W-1:0] div_cnt_q;
  sba_status_e       res_status_q;
  logic [ADDR_W-1:0] res_grant_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              out_valid_q;
  sba_rsp_t          out_q;

  // bitmap memory
  logic [WORD_W-1:0] mem_q [ROWS];
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_vld_q;

  logic              req_fire;
  logic              rsp_fire;
  logic              out_load;
  logic [SIZE_W-1:0] size_eff;
  logic              row_any;
  logic [ROW_W-1:0]  row_sel;
  logic [WORD_W-1:0] word;
  logic              z_any;
  logic [BIT_W-1:0]  z_bit;
  logic [GW-1:0]     alloc_glob;
  logic              alloc_ok;
  logic [WORD_W-1:0] alloc_word;
  logic [WORD_W-1:0] free_word;
  logic              free_hit;
  logic [CNT_W-1:0]  mul_a;
  logic [ADDR_W-1:0] off;
  logic              div_ge;
  logic [GW-1:0]     free_glob;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ROW_W-1:0]  mem_raddr;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.payload = out_q;

  // load the output register once it is empty or drains this cycle
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  assign size_eff = (obj_bytes_q == '0) ? SIZE_W'(1) : obj_bytes_q;

  // lowest row that still has a clear bit
  always_comb begin
    row_any = 1'b0;
    row_sel = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full_q[r]) begin
        row_any = 1'b1;
        row_sel = ROW_W'(r);
      end
    end
  end

  assign word = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    z_any = 1'b0;
    z_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) begin
        z_any = 1'b1;
        z_bit = BIT_W'(b);
      end
    end
  end

  assign alloc_glob = {row_q, z_bit};
  assign alloc_ok   = z_any && (XW'(alloc_glob) < XW'(object_count_q));
  assign alloc_word = word | (WORD_W'(1) << z_bit);
  assign free_word  = word & ~(WORD_W'(1) << bit_q);
  assign free_hit   = word[bit_q];

  always_comb begin
    case (act_q)
      ACT_ALLOC:  mul_a = slot_q;
      ACT_FREE:   mul_a = object_count_q;
      default:    mul_a = CNT_W'(MAX_OBJECTS);
    endcase
  end

  assign off       = addr_q - slab_base_q;
  assign div_ge    = rem_q >= dv_q;
  assign free_glob = GW'(quo_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = alloc_word;
    if (state_q == S_A_WORD && alloc_ok) begin
      mem_we = 1'b1;
    end else if (state_q == S_F_WR && free_hit) begin
      mem_we    = 1'b1;
      mem_wdata = free_word;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = row_sel;
    if (state_q == S_IDLE && req_fire && req_i.payload.action == ACT_ALLOC) begin
      mem_re = 1'b1;
    end else if (state_q == S_POST && act_q == ACT_FREE) begin
      mem_re    = 1'b1;
      mem_raddr = free_glob[GW-1:BIT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[row_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      obj_bytes_q    <= SIZE_W'(RST_OBJ_BYTES);
      slab_base_q    <= '0;
      object_count_q <= CNT_W'(RST_COUNT);
      free_count_q   <= CNT_W'(RST_COUNT);
      row_vld_q      <= '0;
      row_full_q     <= '0;
      rd_vld_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      act_q          <= ACT_NOP;
      div_cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_OBJECT_BYTES) begin
          obj_bytes_q <= cfg_data_i[SIZE_W-1:0];
        end else begin
          slab_base_q <= cfg_data_i[ADDR_W-1:0];
        end
      end

      if (mem_re) begin
        rd_vld_q <= row_vld_q[mem_raddr];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            act_q        <= req_i.payload.action;
            addr_q       <= req_i.payload.free_address;
            res_grant_q  <= '0;
            res_slot_q   <= '0;
            case (req_i.payload.action)
              ACT_ALLOC: begin
                row_q <= row_sel;
                if (free_count_q == '0 || !row_any) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_DONE;
                end else begin
                  res_status_q <= ST_OK;
                  state_q      <= S_A_WORD;
                end
              end
              ACT_FREE: begin
                res_status_q <= ST_OK;
                state_q      <= S_MUL;
              end
              ACT_REINIT: begin
                res_status_q <= ST_OK;
                row_vld_q    <= '0;
                row_full_q   <= '0;
                state_q      <= S_MUL;
              end
              default: begin
                res_status_q <= ST_OK;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_A_WORD: begin
          if (alloc_ok) begin
            row_vld_q[row_q]  <= 1'b1;
            row_full_q[row_q] <= &alloc_word;
            free_count_q      <= free_count_q - CNT_W'(1);
            slot_q            <= CNT_W'(alloc_glob);
            res_slot_q        <= SLOT_W'(alloc_glob);
            state_q           <= S_MUL;
          end else begin
            res_status_q <= ST_FULL;
            state_q      <= S_DONE;
          end
        end
        S_MUL: begin
          mul_q   <= OFF_W'(mul_a) * OFF_W'(size_eff);
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          div_cnt_q <= '0;
          dv_q      <= OFF_W'(size_eff) << (CNT_W - 1);
          quo_q     <= '0;
          case (act_q)
            ACT_ALLOC: begin
              res_grant_q <= slab_base_q + ADDR_W'(mul_q);
              state_q     <= S_DONE;
            end
            ACT_FREE: begin
              if (addr_q < slab_base_q || off >= ADDR_W'(mul_q)) begin
                res_status_q <= ST_BAD_ADDR;
                state_q      <= S_DONE;
              end else begin
                rem_q   <= OFF_W'(off);
                state_q <= S_DIV;
              end
            end
            default: begin
              // saturate when the bitmap depth fits inside the slab
              if (mul_q <= OFF_W'(SLAB_BYTES)) begin
                object_count_q <= CNT_W'(MAX_OBJECTS);
                free_count_q   <= CNT_W'(MAX_OBJECTS);
                state_q        <= S_DONE;
              end else begin
                rem_q   <= OFF_W'(SLAB_BYTES);
                state_q <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_ge) begin
            rem_q <= rem_q - dv_q;
          end
          quo_q     <= {quo_q[CNT_W-2:0], div_ge};
          dv_q      <= dv_q >> 1;
          div_cnt_q <= div_cnt_q + DCNT_W'(1);
          if (div_cnt_q == DCNT_W'(CNT_W - 1)) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (act_q == ACT_FREE) begin
            row_q <= free_glob[GW-1:BIT_W];
            bit_q <= free_glob[BIT_W-1:0];
            if (rem_q != '0) begin
              res_status_q <= ST_BAD_ADDR;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_F_WR;
            end
          end else begin
            object_count_q <= quo_q;
            free_count_q   <= quo_q;
            state_q        <= S_DONE;
          end
        end
        S_F_WR: begin
          if (free_hit) begin
            row_vld_q[row_q]  <= 1'b1;
            row_full_q[row_q] <= 1'b0;
            free_count_q      <= free_count_q + CNT_W'(1);
            res_slot_q        <= SLOT_W'({row_q, bit_q});
          end else begin
            res_status_q <= ST_NOT_ALLOC;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_q.status          <= res_status_q;
            out_q.granted_address <= res_grant_q;
            out_q.slot_index      <= res_slot_q;
            out_q.free_left       <= FREE_W'(free_count_q);
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SBA_ASSERT_NOW(a_free_le_count, 1'b1, free_count_q <= object_count_q)
  `SBA_ASSERT_NOW(a_slot_zero_on_err, out_valid_q && out_q.status != ST_OK, out_q.slot_index == '0)
  `SBA_ASSERT_NEXT(a_busy_after_accept, req_fire, state_q != S_IDLE)
  `SBA_ASSERT_NOW(a_grant_only_alloc, out_valid_q && out_q.granted_address != '0, out_q.status == ST_OK)

endmodule
